>>> hw/rtl/hfwhm_pkg.sv
`default_nettype none

package hfwhm_pkg;

    // Store depth and derived widths
    localparam int MAX_BINS  = 1024;
    localparam int IDX_W     = $clog2(MAX_BINS);
    localparam int CNT_W     = $clog2(MAX_BINS + 1);
    localparam int VAL_W     = 32;
    localparam int OUT_IDX_W = 10;
    localparam int ST_W      = 2;

    // Result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_FEW     = 2'd1,
        ST_NO_HIGH = 2'd2,
        ST_NO_LOW  = 2'd3
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        S_LOAD,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_FIN
    } t_state;

    // Store access request from the sequencer
    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [VAL_W-1:0] wr_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } t_store_req;

endpackage

`default_nettype wire

>>> hw/rtl/hfwhm_if.sv
`default_nettype none

interface hfwhm_in_if;
    logic                        valid;
    logic                        ready;
    logic [hfwhm_pkg::VAL_W-1:0] bin_value;
    logic                        last_bin;

    modport source (output valid, output bin_value, output last_bin, input ready);
    modport sink (input valid, input bin_value, input last_bin, output ready);
endinterface

interface hfwhm_out_if;
    logic                            valid;
    logic                            ready;
    hfwhm_pkg::t_status              status;
    logic [hfwhm_pkg::OUT_IDX_W-1:0] low_edge_bin;
    logic [hfwhm_pkg::OUT_IDX_W-1:0] high_edge_bin;
    logic [hfwhm_pkg::OUT_IDX_W-1:0] peak_bin;
    logic [hfwhm_pkg::VAL_W-1:0]     peak_value;

    modport source (output valid, output status, output low_edge_bin,
                    output high_edge_bin, output peak_bin, output peak_value,
                    input ready);
    modport sink (input valid, input status, input low_edge_bin,
                  input high_edge_bin, input peak_bin, input peak_value,
                  output ready);
endinterface

`default_nettype wire

>>> hw/rtl/hfwhm_store.sv
`default_nettype none

module hfwhm_store (
    input  wire logic                        i_clk,
    input  wire hfwhm_pkg::t_store_req       i_req,
    output logic [hfwhm_pkg::VAL_W-1:0]      o_rd_data
);

    logic [hfwhm_pkg::VAL_W-1:0] r_mem [hfwhm_pkg::MAX_BINS];

    // Write one bin per load transaction
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // Registered read for the edge walks
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            o_rd_data <= r_mem[i_req.rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/hfwhm_half_cmp.sv
`default_nettype none

module hfwhm_half_cmp (
    input  wire logic [hfwhm_pkg::VAL_W-1:0] i_count,
    input  wire logic [hfwhm_pkg::VAL_W-1:0] i_peak,
    output logic                             o_below
);

    // Test 2*count < peak exactly, one bit wider than the count
    assign o_below = {i_count, 1'b0} < {1'b0, i_peak};

endmodule

`default_nettype wire

>>> hw/rtl/histogram_fwhm_finder.sv
// Histogram full-width-at-half-maximum finder.
// Input channel i_bin carries one bin count per transaction, starting at bin 0;
// the transaction with last_bin set closes the histogram and starts the search.
// Bins load at one per cycle while i_bin.ready is high; counts past the store depth are dropped.
// Output channel o_res carries one result per histogram: status, the peak bin
// and its count, and the lower and upper half-maximum bins.
// After the last bin, the search walks the bin store through one read port,
// reading and then comparing each bin visited: upward from the peak to the
// upper edge, then downward from the peak to the lower edge. With fewer than
// three bins no walk is made and the result goes straight to the hand-off.
// i_bin.ready is low during the search. Loading of the next histogram may go
// on while a result waits in the output register; if o_res is stalled when the
// next search ends, the block holds that result and stays not ready.
// Reset (synchronous, active low) empties the load, drops any pending result
// and returns to loading; the store contents are not cleared.
`default_nettype none

module histogram_fwhm_finder (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    hfwhm_in_if.sink   i_bin,
    hfwhm_out_if.source o_res
);

    localparam int IDX_W     = hfwhm_pkg::IDX_W;
    localparam int CNT_W     = hfwhm_pkg::CNT_W;
    localparam int VAL_W     = hfwhm_pkg::VAL_W;
    localparam int OUT_IDX_W = hfwhm_pkg::OUT_IDX_W;

    hfwhm_pkg::t_state     r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [VAL_W-1:0]      r_prev, n_prev;
    logic [VAL_W-1:0]      r_best_val, n_best_val;
    logic [IDX_W-1:0]      r_best_idx, n_best_idx;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [IDX_W-1:0]      r_up, n_up;
    logic [IDX_W-1:0]      r_dn, n_dn;
    hfwhm_pkg::t_status    r_status, n_status;

    logic                  r_out_valid, n_out_valid;
    hfwhm_pkg::t_status    r_out_status, n_out_status;
    logic [OUT_IDX_W-1:0]  r_out_low, n_out_low;
    logic [OUT_IDX_W-1:0]  r_out_high, n_out_high;
    logic [OUT_IDX_W-1:0]  r_out_peak, n_out_peak;
    logic [VAL_W-1:0]      r_out_pval, n_out_pval;

    hfwhm_pkg::t_store_req w_req;
    logic [VAL_W-1:0]      w_rd_data;
    logic                  w_below;
    logic                  w_accept;
    logic                  w_room;
    logic [CNT_W-1:0]      w_cnt_after;
    logic [CNT_W-1:0]      w_last_idx;
    logic [CNT_W-1:0]      w_next_last;
    logic                  w_at_last;
    logic                  w_out_free;

    hfwhm_store u_store (
        .i_clk     (i_clk),
        .i_req     (w_req),
        .o_rd_data (w_rd_data)
    );

    hfwhm_half_cmp u_cmp (
        .i_count (w_rd_data),
        .i_peak  (r_best_val),
        .o_below (w_below)
    );

    assign i_bin.ready = (r_state == hfwhm_pkg::S_LOAD);
    assign w_accept    = i_bin.valid && i_bin.ready;
    assign w_room      = r_count < CNT_W'(hfwhm_pkg::MAX_BINS);
    assign w_cnt_after = w_room ? r_count + CNT_W'(1) : r_count;
    assign w_last_idx  = r_count - CNT_W'(1);
    assign w_next_last = r_count - CNT_W'(2);
    assign w_at_last   = ({1'b0, r_idx} == w_last_idx);
    assign w_out_free  = !r_out_valid || o_res.ready;

    // Store access: write on load, read at the walk index
    always_comb begin
        w_req.wr_en   = w_accept && w_room;
        w_req.wr_addr = r_count[IDX_W-1:0];
        w_req.wr_data = i_bin.bin_value;
        w_req.rd_en   = (r_state == hfwhm_pkg::S_UP_RD) || (r_state == hfwhm_pkg::S_DN_RD);
        w_req.rd_addr = r_idx;
    end

    // Sequencer: load, walk up, walk down, hand off result
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_prev       = r_prev;
        n_best_val   = r_best_val;
        n_best_idx   = r_best_idx;
        n_idx        = r_idx;
        n_up         = r_up;
        n_dn         = r_dn;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_status = r_out_status;
        n_out_low    = r_out_low;
        n_out_high   = r_out_high;
        n_out_peak   = r_out_peak;
        n_out_pval   = r_out_pval;

        case (r_state)
            hfwhm_pkg::S_LOAD: begin
                if (w_accept) begin
                    // Store the bin; the one before it is now interior
                    if (w_room) begin
                        n_count = w_cnt_after;
                        n_prev  = i_bin.bin_value;
                        if (r_count >= CNT_W'(2)) begin
                            if (r_count == CNT_W'(2) || r_prev > r_best_val) begin
                                n_best_val = r_prev;
                                n_best_idx = IDX_W'(r_count - CNT_W'(1));
                            end
                        end
                    end
                    if (i_bin.last_bin) begin
                        if (w_cnt_after < CNT_W'(3)) begin
                            n_status = hfwhm_pkg::ST_FEW;
                            n_state  = hfwhm_pkg::S_FIN;
                        end else begin
                            n_idx   = n_best_idx;
                            n_state = hfwhm_pkg::S_UP_RD;
                        end
                    end
                end
            end
            hfwhm_pkg::S_UP_RD: begin
                n_state = hfwhm_pkg::S_UP_CMP;
            end
            hfwhm_pkg::S_UP_CMP: begin
                // Upper edge: below half, or the last bin unless peak abuts it
                if (w_below || (w_at_last && ({1'b0, r_best_idx} != w_next_last))) begin
                    n_up    = r_idx;
                    n_idx   = r_best_idx;
                    n_state = hfwhm_pkg::S_DN_RD;
                end else if (w_at_last) begin
                    n_status = hfwhm_pkg::ST_NO_HIGH;
                    n_state  = hfwhm_pkg::S_FIN;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = hfwhm_pkg::S_UP_RD;
                end
            end
            hfwhm_pkg::S_DN_RD: begin
                n_state = hfwhm_pkg::S_DN_CMP;
            end
            hfwhm_pkg::S_DN_CMP: begin
                // Lower edge: below half, or bin 0 unless the peak is bin 1
                if (w_below || (r_idx == '0 && r_best_idx != IDX_W'(1))) begin
                    n_dn     = r_idx;
                    n_status = hfwhm_pkg::ST_OK;
                    n_state  = hfwhm_pkg::S_FIN;
                end else if (r_idx == '0) begin
                    n_status = hfwhm_pkg::ST_NO_LOW;
                    n_state  = hfwhm_pkg::S_FIN;
                end else begin
                    n_idx   = r_idx - IDX_W'(1);
                    n_state = hfwhm_pkg::S_DN_RD;
                end
            end
            hfwhm_pkg::S_FIN: begin
                // Hand off once the output register frees, then clear the load
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_low    = '0;
                    n_out_high   = '0;
                    n_out_peak   = '0;
                    n_out_pval   = '0;
                    if (r_status != hfwhm_pkg::ST_FEW) begin
                        n_out_peak = OUT_IDX_W'(r_best_idx);
                        n_out_pval = r_best_val;
                    end
                    if (r_status == hfwhm_pkg::ST_OK) begin
                        n_out_low  = OUT_IDX_W'(r_dn);
                        n_out_high = OUT_IDX_W'(r_up);
                    end
                    n_count    = '0;
                    n_best_val = '0;
                    n_best_idx = '0;
                    n_state    = hfwhm_pkg::S_LOAD;
                end
            end
            default: begin
                n_state = hfwhm_pkg::S_LOAD;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hfwhm_pkg::S_LOAD;
            r_count     <= '0;
            r_best_val  <= '0;
            r_best_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_best_val  <= n_best_val;
            r_best_idx  <= n_best_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and payload registers
    always_ff @(posedge i_clk) begin
        r_prev       <= n_prev;
        r_idx        <= n_idx;
        r_up         <= n_up;
        r_dn         <= n_dn;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_low    <= n_out_low;
        r_out_high   <= n_out_high;
        r_out_peak   <= n_out_peak;
        r_out_pval   <= n_out_pval;
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_out_status;
    assign o_res.low_edge_bin  = r_out_low;
    assign o_res.high_edge_bin = r_out_high;
    assign o_res.peak_bin      = r_out_peak;
    assign o_res.peak_value    = r_out_pval;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(hfwhm_pkg::MAX_BINS))
        else $error("bin count exceeds store depth");

    a_ok_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == hfwhm_pkg::ST_OK) |->
        (r_out_low <= r_out_peak && r_out_peak <= r_out_high))
        else $error("edges do not bracket the peak");

    a_few_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == hfwhm_pkg::ST_FEW) |->
        (r_out_pval == '0 && r_out_peak == '0))
        else $error("short histogram result carries a peak");

    a_search_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_bin.last_bin) |=> !i_bin.ready)
        else $error("input accepted right after the last bin");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_histogram_fwhm_finder.sv
`timescale 1ns / 100ps

module tb_histogram_fwhm_finder;

    // Expected result of one histogram, laid out as on the output channel
    typedef struct packed {
        hfwhm_pkg::t_status                status;
        logic [hfwhm_pkg::OUT_IDX_W-1:0]   low_edge_bin;
        logic [hfwhm_pkg::OUT_IDX_W-1:0]   high_edge_bin;
        logic [hfwhm_pkg::OUT_IDX_W-1:0]   peak_bin;
        logic [hfwhm_pkg::VAL_W-1:0]       peak_value;
    } t_fwhm_result;

    // One bin waiting to be sent; drain holds it until all results are in
    typedef struct {
        logic [hfwhm_pkg::VAL_W-1:0] value;
        logic                        last;
        int                          phase;
        bit                          drain;
    } t_bin_item;

    localparam int BIG_BINS  = hfwhm_pkg::MAX_BINS + 3;
    localparam int RND_ITEMS = 240;

    logic clk;
    logic rst_n;

    hfwhm_in_if  bin_if ();
    hfwhm_out_if res_if ();

    histogram_fwhm_finder uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_bin   (bin_if),
        .o_res   (res_if)
    );

    // Percent of cycles spent idle, per phase
    int send_idle_pct [3] = '{14, 74, 0};
    int recv_idle_pct [3] = '{74, 14, 0};

    t_bin_item                   pending_bins [$];
    t_fwhm_result                expected_results [$];
    logic [hfwhm_pkg::VAL_W-1:0] hist_buf [$];
    int                          drive_phase = 0;

    int mismatches     = 0;
    int results_seen   = 0;
    int bins_accepted  = 0;
    int histograms     = 0;
    int status_tally [4] = '{0, 0, 0, 0};

    // Shadow of the block: bin store and running peak of the interior bins
    logic [hfwhm_pkg::VAL_W-1:0] bin_mem [hfwhm_pkg::MAX_BINS];
    int unsigned                 bins_held  = 0;
    logic [hfwhm_pkg::VAL_W-1:0] peak_count = '0;
    int unsigned                 peak_idx   = 0;
    bit                          peak_seen  = 1'b0;

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Exact half-maximum test: 2*count < peak, without overflow
    function automatic bit under_half(logic [hfwhm_pkg::VAL_W-1:0] count,
                                      logic [hfwhm_pkg::VAL_W-1:0] peak);
        return {1'b0, count, 1'b0} < {2'b00, peak};
    endfunction

    // Absorb one accepted bin; on the last bin, search and queue the result
    task automatic predict_bin(logic [hfwhm_pkg::VAL_W-1:0] value, logic last);
        t_fwhm_result res;
        int unsigned  n, i, up, dn;
        bit           got_up, got_dn;
        if (bins_held < hfwhm_pkg::MAX_BINS) begin
            bin_mem[bins_held] = value;
            bins_held++;
            // the bin before the newest one is now interior
            if (bins_held >= 3) begin
                i = bins_held - 2;
                if (!peak_seen || bin_mem[i] > peak_count) begin
                    peak_count = bin_mem[i];
                    peak_idx   = i;
                    peak_seen  = 1'b1;
                end
            end
        end
        if (!last)
            return;
        res = '0;
        n = bins_held;
        if (!peak_seen || n < 3) begin
            res.status = hfwhm_pkg::ST_FEW;
        end else begin
            // walk upward; the last bin counts unless the peak is next to it
            got_up = 1'b0;
            up = 0;
            for (i = peak_idx; i < n && !got_up; i++) begin
                if (under_half(bin_mem[i], peak_count) || (i == n - 1 && peak_idx != n - 2)) begin
                    up = i;
                    got_up = 1'b1;
                end
            end
            // walk downward; bin 0 counts unless the peak is bin 1
            got_dn = 1'b0;
            dn = 0;
            i = peak_idx + 1;
            while (got_up && !got_dn && i > 0) begin
                i--;
                if (under_half(bin_mem[i], peak_count) || (i == 0 && peak_idx != 1)) begin
                    dn = i;
                    got_dn = 1'b1;
                end
            end
            if (!got_up)
                res.status = hfwhm_pkg::ST_NO_HIGH;
            else if (!got_dn)
                res.status = hfwhm_pkg::ST_NO_LOW;
            else begin
                res.status        = hfwhm_pkg::ST_OK;
                res.low_edge_bin  = hfwhm_pkg::OUT_IDX_W'(dn);
                res.high_edge_bin = hfwhm_pkg::OUT_IDX_W'(up);
            end
            res.peak_bin   = hfwhm_pkg::OUT_IDX_W'(peak_idx);
            res.peak_value = peak_count;
        end
        expected_results = {expected_results, res};
        bins_held  = 0;
        peak_count = '0;
        peak_idx   = 0;
        peak_seen  = 1'b0;
    endtask

    // Move the staged histogram into the send queue
    task automatic queue_histogram(int phase, bit drain);
        t_bin_item item;
        foreach (hist_buf[k]) begin
            item.value = hist_buf[k];
            item.last  = (k == hist_buf.size() - 1);
            item.phase = phase;
            item.drain = drain && (k == 0);
            pending_bins = {pending_bins, item};
        end
        hist_buf.delete();
        histograms++;
    endtask

    // Stage a random histogram: noise, plateau, threshold probe or a peak
    task automatic make_histogram(int nbins, int kind);
        logic [hfwhm_pkg::VAL_W-1:0] h, v;
        int                          c, w, d, sh, a, b;
        h = ($urandom_range(3) == 0) ? hfwhm_pkg::VAL_W'($urandom_range(1000))
                                     : hfwhm_pkg::VAL_W'($urandom);
        if ($urandom_range(15) == 0)
            h = '1;
        c = $urandom_range(nbins - 1);
        w = $urandom_range(1, 8);
        a = $urandom_range(nbins - 1);
        b = $urandom_range(a, nbins - 1);
        hist_buf.delete();
        for (int i = 0; i < nbins; i++) begin
            d = (i > c) ? i - c : c - i;
            case (kind)
                0: v = $urandom;
                1: v = (i >= a && i <= b) ? h : hfwhm_pkg::VAL_W'($urandom_range(h >> 1));
                2: begin
                    case ($urandom_range(3))
                        0: v = h >> 1;
                        1: v = (h >> 1) + 1;
                        2: v = (h >> 1) - 1;
                        default: v = h;
                    endcase
                    if (i == c)
                        v = h;
                end
                default: begin
                    sh = d * d / w;
                    v = (sh > 31) ? '0 : h >> sh;
                    v ^= $urandom & (h >> $urandom_range(2, 12));
                end
            endcase
            hist_buf = {hist_buf, v};
        end
    endtask

    // Driver: predict on each accepted transaction, then offer the next bin
    always @(posedge clk) begin
        t_bin_item nxt;
        if (!rst_n) begin
            bin_if.valid     <= 1'b0;
            bin_if.bin_value <= '0;
            bin_if.last_bin  <= 1'b0;
        end else begin
            if (bin_if.valid && bin_if.ready) begin
                predict_bin(bin_if.bin_value, bin_if.last_bin);
                bins_accepted++;
            end
            if (!bin_if.valid || bin_if.ready) begin
                if (pending_bins.size() != 0
                    && !(pending_bins[0].drain && expected_results.size() != 0)
                    && $urandom_range(99) >= send_idle_pct[pending_bins[0].phase]) begin
                    nxt = pending_bins.pop_front();
                    bin_if.valid     <= 1'b1;
                    bin_if.bin_value <= nxt.value;
                    bin_if.last_bin  <= nxt.last;
                    drive_phase      <= nxt.phase;
                end else begin
                    bin_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transaction against the oldest expectation
    always @(posedge clk) begin
        t_fwhm_result want, got;
        if (!rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                got.status        = res_if.status;
                got.low_edge_bin  = res_if.low_edge_bin;
                got.high_edge_bin = res_if.high_edge_bin;
                got.peak_bin      = res_if.peak_bin;
                got.peak_value    = res_if.peak_value;
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: st %0d lo %0d hi %0d pk %0d val %0h",
                                 got.status, got.low_edge_bin, got.high_edge_bin,
                                 got.peak_bin, got.peak_value);
                end else begin
                    want = expected_results.pop_front();
                    status_tally[want.status]++;
                    if (got.status !== want.status || got.low_edge_bin !== want.low_edge_bin
                        || got.high_edge_bin !== want.high_edge_bin
                        || got.peak_bin !== want.peak_bin
                        || got.peak_value !== want.peak_value) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("res %0d want: st %0d lo %0d hi %0d pk %0d val %0h",
                                     results_seen, want.status, want.low_edge_bin,
                                     want.high_edge_bin, want.peak_bin, want.peak_value);
                            $display("res %0d got:  st %0d lo %0d hi %0d pk %0d val %0h",
                                     results_seen, got.status, got.low_edge_bin,
                                     got.high_edge_bin, got.peak_bin, got.peak_value);
                        end
                    end
                end
            end
            res_if.ready <= ($urandom_range(99) >= recv_idle_pct[drive_phase]);
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int rnd_items, nbins, ph, last_ph, r;
        rst_n = 1'b0;

        // single bin and two bins: too few for an interior bin
        hist_buf = '{32'hFFFF_FFFF};
        queue_histogram(0, 1'b0);
        hist_buf = '{32'd5, 32'd6};
        queue_histogram(0, 1'b0);
        // extreme counts around the half threshold; upper edge taken at the last bin
        hist_buf = '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        queue_histogram(0, 1'b0);
        // peak next to the last bin, which is not below half: no upper edge
        hist_buf = '{32'd1, 32'd2, 32'd10, 32'd6};
        queue_histogram(0, 1'b0);
        // peak at bin 1, bin 0 not below half: no lower edge
        hist_buf = '{32'd8, 32'd10, 32'd3, 32'd2};
        queue_histogram(0, 1'b0);
        // tied maximum keeps the first; a count of exactly half is not an edge
        hist_buf = '{32'd0, 32'd3, 32'd10, 32'd10, 32'd5, 32'd2, 32'd1};
        queue_histogram(0, 1'b0);
        // all zeros: nothing lies below half of zero
        hist_buf = '{32'd0, 32'd0, 32'd0};
        queue_histogram(0, 1'b0);

        // random histograms over three idling phases, one past the store depth
        rnd_items = 0;
        last_ph = -1;
        while (rnd_items < RND_ITEMS) begin
            ph = (rnd_items < RND_ITEMS / 3) ? 0 : (rnd_items < 2 * RND_ITEMS / 3) ? 1 : 2;
            if (ph == 1 && last_ph == 0) begin
                make_histogram(BIG_BINS, 1);
                queue_histogram(ph, 1'b1);
                last_ph = ph;
            end
            r = $urandom_range(99);
            nbins = (r < 5) ? $urandom_range(1, 2)
                  : (r < 85) ? $urandom_range(3, 20) : $urandom_range(21, 60);
            r = $urandom_range(9);
            make_histogram(nbins, (r < 3) ? r : 3);
            queue_histogram(ph, ph != last_ph);
            last_ph = ph;
            rnd_items += nbins;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // drain: all bins sent, all results in, then a quiet margin
        wait (pending_bins.size() == 0);
        @(negedge clk);
        while (bin_if.valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        mismatches += expected_results.size();

        $display("Sent %0d bins in %0d histograms, one of %0d bins beyond the store depth",
                 bins_accepted, histograms, BIG_BINS);
        $display("Got %0d results: ok %0d, too few %0d, no upper edge %0d, no lower edge %0d",
                 results_seen, status_tally[hfwhm_pkg::ST_OK],
                 status_tally[hfwhm_pkg::ST_FEW], status_tally[hfwhm_pkg::ST_NO_HIGH],
                 status_tally[hfwhm_pkg::ST_NO_LOW]);
        if (mismatches == 0)
            $display("histogram_fwhm_finder: match");
        else
            $display("histogram_fwhm_finder: mismatch");
        $finish;
    end

    // Watchdog
    initial begin
        #8_000_000;
        $display("histogram_fwhm_finder: mismatch");
        $finish;
    end

endmodule
